// File: hdl/nrf_pkg.sv
// Shared types, constants and distance helpers for the nearest rectangle finder.
`default_nettype none
package nrf_pkg;
	localparam int MAX_RECTS_DEF = 32;
	localparam int COORD_W       = 32;
	localparam int DIFF_W        = 34;
	localparam int SUM_W         = 69;
	localparam int ROOT_W        = 36;
	localparam int IDX_W         = 5;
	localparam int CNT_W         = 6;
	localparam logic OP_LOAD     = 1'b0;
	localparam logic OP_QUERY    = 1'b1;

	typedef struct packed {
		logic signed [COORD_W-1:0] bottom;
		logic signed [COORD_W-1:0] right;
		logic signed [COORD_W-1:0] top;
		logic signed [COORD_W-1:0] left;
	} rect_t;

	typedef struct packed {
		logic               start;
		logic [DIFF_W-1:0]  dx;
		logic [DIFF_W-1:0]  dy;
	} dist_req_t;

	typedef struct packed {
		logic               done;
		logic [ROOT_W-1:0]  root;
	} dist_rsp_t;

	function automatic logic [DIFF_W-1:0] absdiff(input logic signed [DIFF_W-1:0] a,
		input logic signed [DIFF_W-1:0] b);
		logic signed [DIFF_W-1:0] d;
		d = a - b;
		return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
	endfunction
endpackage
`default_nettype wire

// File: hdl/nearest_rectangle_finder.sv
// Top level of the nearest rectangle finder.
// channel | dir | tdata / tuser
// s_axis  | in  | tuser op; tdata entry_index,bound_left..bound_bottom,point_x,point_y
// m_axis  | out | tdata nearest_index
// cfg     | in  | rect_count
// A load writes its table entry when accepted. A query reads each entry scanned for
// containment; with no hit, each entry is then scored: one read, five square roots
// (request, squaring of dx and dy, root bits 34 down to 0, return) and one compare.
// Reset clears control and rect_count; table contents are undefined until loaded.
// The input stalls while a query runs or its result waits.
`default_nettype none
module nearest_rectangle_finder
	import nrf_pkg::*;
#(
	parameter int MAX_RECTS = MAX_RECTS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [5:0]   cfg_wdata,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [199:0] s_axis_tdata, // entry_index, left, top, right, bottom, x, y
	input  wire logic         s_axis_tuser, // op
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [7:0]        m_axis_tdata  // nearest_index
);
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] idx;
	rect_t rect;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= '0;
		else if (cfg_we) count_q <= cfg_wdata;
	end
	assign rect.left   = s_axis_tdata[36:5];
	assign rect.top    = s_axis_tdata[68:37];
	assign rect.right  = s_axis_tdata[100:69];
	assign rect.bottom = s_axis_tdata[132:101];
	nrf_engine #(.MAX_RECTS(MAX_RECTS)) u_engine (
		.clk(clk), .arst_n(arst_n), .rect_count(count_q),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_op(s_axis_tuser), .in_index(s_axis_tdata[4:0]), .in_rect(rect),
		.in_x(s_axis_tdata[164:133]), .in_y(s_axis_tdata[196:165]),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_index(idx)
	);
	assign m_axis_tdata = {3'b000, idx};
endmodule
`default_nettype wire

// File: hdl/nrf_dist.sv
// Iterative floor square root of dx*dx + dy*dy, one root bit per step.
`default_nettype none
module nrf_dist
	import nrf_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire dist_req_t req,
	output dist_rsp_t      rsp
);
	typedef enum logic [1:0] {S_IDLE, S_SQ, S_ROOT} st_t;
	st_t                st_q;
	logic [DIFF_W-1:0]  dx_q, dy_q;
	logic [SUM_W-1:0]   sum_q, rem_q;
	logic [ROOT_W-1:0]  root_q;
	logic [5:0]         bit_q;
	logic [1:0]         ph_q;
	logic [2*ROOT_W-1:0] prod_q;
	logic               done_q;
	logic [ROOT_W-1:0]  cand;
	logic [SUM_W-1:0]   part;
	assign cand = root_q | (ROOT_W'(1) << bit_q);
	// 34x34 square split into 17-bit halves over cycles
	always_comb begin
		unique case (ph_q)
			2'd0: part = SUM_W'(34'(dx_q[16:0]) * 34'(dx_q[16:0]));
			2'd1: part = SUM_W'(34'(dx_q[33:17]) * 34'(dx_q[16:0])) << 18;
			2'd2: part = SUM_W'(34'(dx_q[33:17]) * 34'(dx_q[33:17])) << 34;
			default: part = '0;
		endcase
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			done_q <= 1'b0;
			ph_q <= '0;
			bit_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				S_IDLE: if (req.start) begin
					dx_q <= req.dx; dy_q <= req.dy; sum_q <= '0;
					ph_q <= '0; rem_q <= '0; st_q <= S_SQ;
				end
				S_SQ: begin
					if (ph_q == 2'd3) begin
						if (rem_q[0]) begin
							// start below the top root bit, whose square exceeds any sum
							rem_q <= sum_q; root_q <= '0;
							bit_q <= 6'(ROOT_W-2); st_q <= S_ROOT;
							prod_q <= '0;
						end else begin
							rem_q[0] <= 1'b1; dx_q <= dy_q; ph_q <= '0;
						end
					end else begin
						sum_q <= sum_q + part;
						ph_q <= ph_q + 2'd1;
					end
				end
				S_ROOT: begin
					// prod_q holds root_q squared; test (r+2^b)^2 = r^2 + r*2^(b+1) + 2^2b
					if (SUM_W'(prod_q) + (SUM_W'(root_q) << (bit_q + 6'd1))
						+ (SUM_W'(1) << (2*bit_q)) <= rem_q) begin
						root_q <= cand;
						prod_q <= (2*ROOT_W)'(SUM_W'(prod_q) + (SUM_W'(root_q) << (bit_q + 6'd1))
							+ (SUM_W'(1) << (2*bit_q)));
					end
					if (bit_q == '0) begin
						st_q <= S_IDLE;
						done_q <= 1'b1;
					end else
						bit_q <= bit_q - 6'd1;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
	assign rsp = {done_q, root_q};
endmodule
`default_nettype wire

// File: hdl/nrf_engine.sv
// Table memory and the scan sequencer for containment and scoring.
`default_nettype none
module nrf_engine
	import nrf_pkg::*;
#(
	parameter int MAX_RECTS = MAX_RECTS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [CNT_W-1:0]   rect_count,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               in_op,
	input  wire logic [IDX_W-1:0]   in_index,
	input  wire rect_t              in_rect,
	input  wire logic signed [COORD_W-1:0] in_x,
	input  wire logic signed [COORD_W-1:0] in_y,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [IDX_W-1:0]        out_index
);
	localparam int AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
	localparam int NW = $clog2(MAX_RECTS + 1);
	typedef enum logic [2:0] {S_IDLE, S_RD, S_CONT, S_PREP, S_DIST, S_NEXT, S_OUT} st_t;
	st_t st_q;
	rect_t mem [MAX_RECTS];
	rect_t rd_q;
	logic [NW-1:0] i_q, n_q;
	logic [1:0] pass_q;
	logic [2:0] k_q;
	logic signed [COORD_W-1:0] x_q, y_q;
	logic [ROOT_W-1:0] d_q, best_s_q;
	logic [IDX_W-1:0] best_q;
	dist_req_t req;
	dist_rsp_t rsp;
	logic signed [DIFF_W-1:0] l, t, r, b, x, y, cx, cy, px, py;
	logic in_x_span, in_y_span;
	logic [ROOT_W-1:0] ed;
	logic [NW-1:0] cnt_sat;
	always_comb begin
		l = DIFF_W'(rd_q.left); t = DIFF_W'(rd_q.top);
		r = DIFF_W'(rd_q.right); b = DIFF_W'(rd_q.bottom);
		x = DIFF_W'(x_q); y = DIFF_W'(y_q);
		cx = l + DIFF_W'(absdiff(l, r) >> 1);
		cy = t + DIFF_W'(absdiff(t, b) >> 1);
		in_x_span = (x >= l) && (x <= r);
		in_y_span = (y >= t) && (y <= b);
		case (k_q)
			3'd0: begin px = cx; py = cy; end
			3'd1: begin px = l; py = t; end
			3'd2: begin px = r; py = t; end
			3'd3: begin px = r; py = b; end
			default: begin px = l; py = b; end
		endcase
		ed = d_q;
		if (in_x_span) begin
			if (ROOT_W'(absdiff(t, y)) < ed) ed = ROOT_W'(absdiff(t, y));
			if (ROOT_W'(absdiff(b, y)) < ed) ed = ROOT_W'(absdiff(b, y));
		end
		if (in_y_span) begin
			if (ROOT_W'(absdiff(l, x)) < ed) ed = ROOT_W'(absdiff(l, x));
			if (ROOT_W'(absdiff(r, x)) < ed) ed = ROOT_W'(absdiff(r, x));
		end
		cnt_sat = (32'(rect_count) > 32'(MAX_RECTS)) ? NW'(MAX_RECTS) : NW'(rect_count);
	end
	assign req.dx = absdiff(px, x);
	assign req.dy = absdiff(py, y);
	assign req.start = (st_q == S_PREP);
	nrf_dist u_dist (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));
	assign in_ready = (st_q == S_IDLE) || (st_q == S_OUT && out_ready);
	assign out_valid = (st_q == S_OUT);
	assign out_index = best_q;
	always_ff @(posedge clk) begin
		if (in_valid && in_ready && in_op == OP_LOAD && 32'(in_index) < 32'(MAX_RECTS))
			mem[AW'(in_index)] <= in_rect;
		rd_q <= mem[AW'(i_q)];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			best_q <= '0;
			i_q <= '0;
		end else begin
			unique case (st_q)
				S_IDLE, S_OUT: begin
					if (st_q == S_OUT && out_ready) st_q <= S_IDLE;
					if (in_valid && in_ready && in_op == OP_QUERY) begin
						x_q <= in_x; y_q <= in_y; n_q <= cnt_sat;
						i_q <= '0; pass_q <= '0; best_q <= '0;
						st_q <= (cnt_sat == '0) ? S_OUT : S_RD;
					end
				end
				S_RD: st_q <= (pass_q == 2'd0) ? S_CONT : S_PREP;
				S_CONT: begin
					if (in_x_span && in_y_span) begin
						best_q <= IDX_W'(i_q); st_q <= S_OUT;
					end else if (i_q + NW'(1) == n_q) begin
						i_q <= '0; pass_q <= 2'd1; k_q <= '0;
						d_q <= '1; st_q <= S_RD;
					end else begin
						i_q <= i_q + NW'(1); st_q <= S_RD;
					end
				end
				S_PREP: st_q <= S_DIST;
				S_DIST: if (rsp.done) begin
					if (rsp.root < d_q) d_q <= rsp.root;
					if (k_q == 3'd4) st_q <= S_NEXT;
					else begin k_q <= k_q + 3'd1; st_q <= S_PREP; end
				end
				S_NEXT: begin
					if (i_q == '0 || ed < best_s_q) begin
						best_s_q <= ed; best_q <= IDX_W'(i_q);
					end
					k_q <= '0; d_q <= '1;
					if (i_q + NW'(1) == n_q) st_q <= S_OUT;
					else begin i_q <= i_q + NW'(1); st_q <= S_RD; end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: hdl/nrf_checker.sv
// Port-level checks for the nearest rectangle finder, bound to the top level.
`default_nettype none
module nrf_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_axis_tready,
	input wire logic       m_axis_tvalid,
	input wire logic       m_axis_tready,
	input wire logic [7:0] m_axis_tdata
);
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[7:5] == 3'b000) else $error("pad bits set");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready) else $error("accept while full");
endmodule
bind nearest_rectangle_finder nrf_checker u_chk (.*);
`default_nettype wire
